// ===== rtl/core/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_cell and wildcard_glob_matcher; no dependencies.
package wgm_pkg;

  localparam int unsigned MaxPatternDef = 64;

  localparam logic [7:0] SymStar = 8'd42;
  localparam logic [7:0] SymAny  = 8'd63;

  typedef enum logic [1:0] {
    CmdPattern = 2'd0,
    CmdText    = 2'd1,
    CmdReport  = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       step;   // text byte: advance reach bits
    logic       clear;  // drop the pattern
    logic       arm;    // reach vector reads as the initial vector
    logic [7:0] sym;
  } ctrl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic valid;  // cell holds a pattern byte
    logic star;   // that byte is a star
    logic init;   // cell is pattern position zero
    logic adv;    // reach moves past this cell on the current byte
    logic pre;    // reach of this position before star closure
  } link_t;

endpackage

// ===== rtl/core/wgm_cell.sv =====
// One pattern position: stored byte, valid flag and reach bit.
// Depends on wgm_pkg.
module wgm_cell #(
  parameter bit IsFirst = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wgm_pkg::ctrl_t ctrl_i,
  input  logic           wr_en_i,
  input  wgm_pkg::link_t link_i,
  output wgm_pkg::link_t link_o,
  output logic           hit_o
);
  import wgm_pkg::*;

  logic [7:0] pat_q;
  logic       valid_q, valid_d;
  logic       reach_q, reach_d;
  logic       star, init, eff, match, pre, nxt;

  assign star  = valid_q & (pat_q == SymStar);
  // runs of stars are collapsed on load, so closure is one cell deep and
  // only position one can be reached through a leading star
  assign init  = IsFirst ? 1'b1 : (link_i.init & link_i.star);
  assign eff   = ctrl_i.arm ? init : reach_q;
  assign match = valid_q & ~star & ((pat_q == SymAny) | (pat_q == ctrl_i.sym));
  assign pre   = (eff & star) | link_i.adv;
  assign nxt   = pre | (link_i.pre & link_i.star);

  // the tail position is the first cell without a pattern byte
  assign hit_o = eff & ~valid_q & (IsFirst ? 1'b1 : link_i.valid);

  assign link_o.valid = valid_q;
  assign link_o.star  = star;
  assign link_o.init  = IsFirst;
  assign link_o.adv   = eff & match;
  assign link_o.pre   = pre;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr_en_i) begin
      valid_d = 1'b1;
    end
    reach_d = ctrl_i.step ? nxt : reach_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      reach_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      reach_q <= reach_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q <= ctrl_i.sym;
    end
  end

endmodule

// ===== rtl/core/wildcard_glob_matcher.sv =====
// Whole-string wildcard matcher ('?' any byte, '*' any run) built as a row of cells.
// Depends on wgm_pkg and wgm_cell.
//
// A text byte updates the reach bit of all MaxPattern+1 cells at once, each
// cell looking only at its left neighbor, so a new word can be taken every
// cycle. A report word leaves its result in an output register; input is
// held off only while that register is full and the sink does not take it.
// Consecutive stars in the pattern are stored as one, which keeps star
// closure to a single neighbor step.
module wildcard_glob_matcher #(
  parameter int unsigned MaxPattern = wgm_pkg::MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] error, [7:2] zero
);
  import wgm_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxPattern + 1);
  localparam int unsigned Cells = MaxPattern + 1;

  logic [LenW-1:0] raw_len_q, raw_len_d;
  logic [LenW-1:0] slen_q, slen_d;
  logic            last_star_q, last_star_d;
  logic            text_q, text_d;
  logic            err_q, err_d;
  logic            arm_q, arm_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_bits_q, out_bits_d;

  logic            accept, store;
  cmd_e            cmd;
  ctrl_t           ctrl;
  link_t           links [Cells];
  logic [Cells-1:0] hits;
  logic [Cells-1:0] wr_en;
  logic            matched;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign matched       = |hits;

  assign store = accept & (cmd == CmdPattern) & ~text_q & (raw_len_q != LenW'(MaxPattern))
               & ~(last_star_q & (s_axis_tdata == SymStar));

  assign ctrl.step  = accept & (cmd == CmdText);
  assign ctrl.clear = accept & (cmd == CmdClear);
  assign ctrl.arm   = arm_q;
  assign ctrl.sym   = s_axis_tdata;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    assign wr_en[i] = store & (slen_q == LenW'(i));
    if (i == 0) begin : g_first
      wgm_cell #(.IsFirst(1'b1)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .wr_en_i (wr_en[i]),
        .link_i  ('0),
        .link_o  (links[i]),
        .hit_o   (hits[i])
      );
    end else begin : g_rest
      wgm_cell #(.IsFirst(1'b0)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .wr_en_i (wr_en[i]),
        .link_i  (links[i-1]),
        .link_o  (links[i]),
        .hit_o   (hits[i])
      );
    end
  end

  always_comb begin
    raw_len_d   = raw_len_q;
    slen_d      = slen_q;
    last_star_d = last_star_q;
    text_d      = text_q;
    err_d       = err_q;
    arm_d       = arm_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_bits_d  = out_bits_q;
    if (accept) begin
      unique case (cmd)
        CmdPattern: begin
          if (text_q || raw_len_q == LenW'(MaxPattern)) begin
            err_d = 1'b1;
          end else begin
            raw_len_d = raw_len_q + LenW'(1);
            arm_d     = 1'b1;
            if (store) begin
              slen_d      = slen_q + LenW'(1);
              last_star_d = (s_axis_tdata == SymStar);
            end
          end
        end
        CmdText: begin
          text_d = 1'b1;
          arm_d  = 1'b0;
        end
        CmdReport: begin
          out_valid_d = 1'b1;
          out_bits_d  = {err_q, matched};
          text_d      = 1'b0;
          arm_d       = 1'b1;
        end
        CmdClear: begin
          raw_len_d   = '0;
          slen_d      = '0;
          last_star_d = 1'b0;
          text_d      = 1'b0;
          err_d       = 1'b0;
          arm_d       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q   <= '0;
      slen_q      <= '0;
      last_star_q <= 1'b0;
      text_q      <= 1'b0;
      err_q       <= 1'b0;
      arm_q       <= 1'b1;
      out_valid_q <= 1'b0;
      out_bits_q  <= '0;
    end else begin
      raw_len_q   <= raw_len_d;
      slen_q      <= slen_d;
      last_star_q <= last_star_d;
      text_q      <= text_d;
      err_q       <= err_d;
      arm_q       <= arm_d;
      out_valid_q <= out_valid_d;
      out_bits_q  <= out_bits_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_bits_q};

  // at most one cell marks the end of the stored pattern
  a_one_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hits))
    else $error("more than one tail hit");

  a_len_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slen_q <= raw_len_q)
    else $error("stored length exceeds raw pattern length");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (slen_q == '0) && !err_q && !text_q && arm_q)
    else $error("clear did not empty the pattern");

  a_report_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CmdReport) |=> out_valid_q && arm_q && !text_q)
    else $error("report did not post a result and re-arm");

endmodule
